FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion shorthands for the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/mstuf_pkg.sv
// ----------------------------------------------------------------------------
// mstuf_pkg
// Types and constants shared by the spanning tree edge acceptance core.
// ----------------------------------------------------------------------------
package mstuf_pkg;

   // default sizing
   localparam int MAX_VERTICES_DEF = 64;
   localparam int WEIGHT_BITS_DEF  = 16;

   // fixed field widths
   localparam int VCW   = 7;   // vertex number / vertex count
   localparam int WFW   = 16;  // weight field
   localparam int COSTW = 22;  // running cost
   localparam int ETW   = 6;   // edges_taken field

   localparam logic [VCW-1:0]   VC_RESET = 7'd64;
   localparam logic [COSTW-1:0] COST_MAX = 22'h3F_FFFF;

   // input beat
   typedef struct packed {
      logic            first_edge;
      logic [WFW-1:0]  edge_weight;
      logic [VCW-1:0]  end_a;
      logic [VCW-1:0]  end_b;
   } req_type;

   // result beat
   typedef struct packed {
      logic             accepted;
      logic [COSTW-1:0] running_cost;
      logic [ETW-1:0]   edges_taken;
      logic             tree_complete;
   } rsp_type;

   // sequencer to forest memory controls
   typedef struct packed {
      logic clear;   // drop every link at once
      logic wr_en;   // link one root under another
   } forest_ctl_type;

endpackage

FILE: hw/rtl/mstuf_forest.sv
// ----------------------------------------------------------------------------
// mstuf_forest
// Parent forest store: one parent entry per vertex, registered read port,
// one write port, per-entry valid bits so a clear drops every entry at once.
// ----------------------------------------------------------------------------
module mstuf_forest
   import mstuf_pkg::*;
#(
   parameter int DEPTH = MAX_VERTICES_DEF,
   parameter int VW    = $clog2(DEPTH + 1),
   parameter int IW    = $clog2(DEPTH)
) (
   input  logic           clock,
   input  logic           reset,
   input  forest_ctl_type ctl,
   input  logic [IW-1:0]  rd_addr,
   input  logic [IW-1:0]  wr_addr,
   input  logic [VW-1:0]  wr_data,
   output logic [VW-1:0]  rd_data
);

   logic [VW-1:0]    mem_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff, vld_in;
   logic [VW-1:0]    rd_data_ff;
   logic             rd_vld_ff, rd_vld_in;

   // valid bits: clear all, or mark the linked entry
   always_comb begin
      vld_in = vld_ff;
      if (ctl.clear) begin
         vld_in = '0;
      end else if (ctl.wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   // a read issued in the clearing cycle sees a root
   assign rd_vld_in = ctl.clear ? 1'b0 : vld_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   // data array and registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // unwritten entry reads as zero (root)
   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

FILE: hw/rtl/mst_edge_union_find_core.sv
// ----------------------------------------------------------------------------
// mst_edge_union_find_core
// Edge acceptance stage of a minimum spanning tree builder (union-find).
// ----------------------------------------------------------------------------
// Usage:
//   Edges come in on the req_ channel in ascending weight order, one beat per
//   edge; each edge gives exactly one rsp_ beat with accept flag, running
//   cost, edge count and tree-complete flag. Both channels use valid/stall.
//   csr_we/csr_wdata write the vertex count; the user must write it only while
//   the core is idle, which the core does not enforce. A beat with first_edge
//   set drops the forest and the totals first.
// Timing: an edge walks end_a and then end_b to their roots through the
//   single forest read port, one parent hop per cycle; an out-of-range edge
//   skips the walk. A finish step links the two roots if they differ, updates
//   the totals and loads the result. req_stall stays high from accept until
//   the result is loaded into the output register.
// Reset: synchronous; empties the forest, clears the totals, vertex count 64.
// Stall: a result waits in the output register under rsp_stall; the next edge
//   may be accepted and walked meanwhile, but finishes only once it is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mst_edge_union_find_core
   import mstuf_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   // edge input
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type        req_data,
   // result output
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp_data,
   // vertex count register
   input  logic           csr_we,
   input  logic [VCW-1:0] csr_wdata
);

   // vertex numbers never exceed 127, so deeper storage would go unused
   localparam int DEPTH  = (MAX_VERTICES < 127) ? MAX_VERTICES : 127;
   localparam int VW     = $clog2(DEPTH + 1);
   localparam int IW     = $clog2(DEPTH);
   localparam int CW     = $clog2(DEPTH);
   localparam int WB     = (WEIGHT_BITS < WFW) ? WEIGHT_BITS : WFW;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WALK_A = 2'd1;
   localparam logic [1:0] S_WALK_B = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [VW-1:0]    cur_ff, cur_in;
   logic [VW-1:0]    root_a_ff, root_a_in;
   logic [VW-1:0]    b_ff, b_in;
   logic [WB-1:0]    w_ff, w_in;
   logic             ok_ff, ok_in;
   logic [COSTW-1:0] cost_ff, cost_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [VCW-1:0]   vc_ff, vc_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   forest_ctl_type   fctl;
   logic [IW-1:0]    rd_addr, wr_addr;
   logic [VW-1:0]    parent;

   logic             req_accept;
   logic             out_free;
   logic             fin_go, fin_take;
   logic [VCW-1:0]   n_live, n_less;
   logic [CW-1:0]    count_eff, count_new;
   logic             a_ok, b_ok, edge_ok;
   logic [COSTW:0]   cost_sum;

   // handshake
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // effective vertex count, saturated into [2, DEPTH]
   always_comb begin
      priority if (vc_ff < VCW'(2)) begin
         n_live = VCW'(2);
      end else if (int'(vc_ff) > DEPTH) begin
         n_live = VCW'(DEPTH);
      end else begin
         n_live = vc_ff;
      end
   end
   assign n_less = n_live - VCW'(1);

   // range checks at accept, against totals after an optional clear
   assign count_eff = req_data.first_edge ? '0 : count_ff;
   assign a_ok      = (req_data.end_a != '0) && (req_data.end_a <= n_live);
   assign b_ok      = (req_data.end_b != '0) && (req_data.end_b <= n_live);
   assign edge_ok   = a_ok && b_ok && (VCW'(count_eff) < n_less);

   // finish step: link, totals, load result
   assign fin_go    = (state_ff == S_FINISH) && out_free;
   assign fin_take  = ok_ff && (root_a_ff != cur_ff);
   assign cost_sum  = {1'b0, cost_ff} + (COSTW + 1)'(w_ff);
   assign count_new = fin_take ? count_ff + CW'(1) : count_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      root_a_in = root_a_ff;
      b_in      = b_ff;
      w_in      = w_ff;
      ok_in     = ok_ff;
      cost_in   = cost_ff;
      count_in  = count_ff;
      rd_addr   = '0;
      fctl      = '0;
      wr_addr   = IW'(cur_ff - VW'(1));
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = IW'(req_data.end_a - VCW'(1));
            if (req_accept) begin
               fctl.clear = req_data.first_edge;
               if (req_data.first_edge) begin
                  cost_in  = '0;
                  count_in = '0;
               end
               cur_in   = VW'(req_data.end_a);
               b_in     = VW'(req_data.end_b);
               w_in     = req_data.edge_weight[WB-1:0];
               ok_in    = edge_ok;
               state_in = edge_ok ? S_WALK_A : S_FINISH;
            end
         end
         S_WALK_A: begin
            // one hop per cycle; at the root start walking from end_b
            if (parent == '0) begin
               root_a_in = cur_ff;
               cur_in    = b_ff;
               rd_addr   = IW'(b_ff - VW'(1));
               state_in  = S_WALK_B;
            end else begin
               cur_in  = parent;
               rd_addr = IW'(parent - VW'(1));
            end
         end
         S_WALK_B: begin
            rd_addr = IW'(parent - VW'(1));
            if (parent == '0) begin
               state_in = S_FINISH;
            end else begin
               cur_in = parent;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               fctl.wr_en = fin_take;
               if (fin_take) begin
                  cost_in  = cost_sum[COSTW] ? COST_MAX : cost_sum[COSTW-1:0];
                  count_in = count_new;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fin_go) begin
         rsp_in.accepted      = fin_take;
         rsp_in.running_cost  = cost_in;
         rsp_in.edges_taken   = ETW'(count_new);
         rsp_in.tree_complete = (VCW'(count_new) == n_less);
         rsp_valid_in         = 1'b1;
      end
   end

   // vertex count register
   assign vc_in = csr_we ? csr_wdata : vc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cost_ff      <= '0;
         count_ff     <= '0;
         vc_ff        <= VC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cost_ff      <= cost_in;
         count_ff     <= count_in;
         vc_ff        <= vc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      root_a_ff <= root_a_in;
      b_ff      <= b_in;
      w_ff      <= w_in;
      ok_ff     <= ok_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // parent forest
   mstuf_forest #(
      .DEPTH (DEPTH),
      .VW    (VW),
      .IW    (IW)
   ) u_forest (
      .clock   (clock),
      .reset   (reset),
      .ctl     (fctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (root_a_ff),
      .rd_data (parent)
   );

   // checks
   `ASSERT_NXT(a_busy_after_accept, clock, reset, req_accept, req_stall, "core idle after accept")
   `ASSERT_IMP(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_FINISH, "result loaded outside finish")
   `ASSERT_NXT(a_count_step, clock, reset, fin_go && fin_take, count_ff == CW'($past(count_ff) + CW'(1)), "edge count did not step")

endmodule
